@@ src/rmsp_pkg.sv @@
`default_nettype none
package rmsp_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_BITS   = 16;
    localparam int SP_BITS     = $clog2(STACK_DEPTH);
    localparam int TOP_BITS    = SP_BITS + 1;
    localparam int MEM_WORDS   = 1 << ADDR_BITS;

    localparam logic [2:0] OP_CALL   = 3'd0;
    localparam logic [2:0] OP_RETURN = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_ADD    = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] func_id;
        logic [15:0] addr;
        logic [15:0] length;
        logic [31:0] cost_in;
    } req_t;

    typedef struct packed {
        logic [31:0]        out_func_id;
        logic [31:0]        call_stamp;
        logic signed [31:0] read_size;
        logic [47:0]        total_cost;
        logic               is_root;
    } rsp_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;          // latch request
        logic do_call;
        logic ret_rd;        // start return: add cost_in to top frame
        logic ret_wr;        // finish return
        logic do_add;
        logic clr_step;      // write zero at clear address
        logic byte_rd;       // write current stamp at cursor while its old stamp is read out
        logic byte_chk;      // compare old stamp, update top
        logic srch_step;
        logic srch_dec;      // apply decrement at search index
        logic advance;       // next byte
        logic out_take;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       len_zero;
        logic       last_byte;
        logic       clr_done;
        logic       need_srch;
        logic       srch_hit;
        logic       srch_end;
        logic       out_busy;
    } sts_t;
endpackage
`default_nettype wire

@@ src/rmsp_ram.sv @@
`default_nettype none
module rmsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/rmsp_datapath.sv @@
`default_nettype none
module rmsp_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rmsp_pkg::req_t req,
    input  wire rmsp_pkg::cmd_t cmd,
    output rmsp_pkg::sts_t     sts,
    output rmsp_pkg::rsp_t     rsp,
    output logic               rsp_valid
);
    import rmsp_pkg::*;

    req_t                 req_reg;
    logic [31:0]          counter_reg;
    logic [TOP_BITS-1:0]  top_reg;
    logic [ADDR_BITS:0]   clr_reg;
    logic [ADDR_BITS-1:0] cur_reg;
    logic [15:0]          left_reg;
    logic [SP_BITS-1:0]   srch_reg;
    logic [31:0]          old_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    // top frame lives in registers; older frames sit in the frame RAMs
    logic [31:0] tf_func_reg;
    logic [31:0] tf_stamp_reg;
    logic [31:0] tf_size_reg;
    logic [47:0] tf_cost_reg;

    logic [SP_BITS-1:0] tix;
    logic [SP_BITS-1:0] pix;
    assign tix = SP_BITS'(top_reg - 1'b1);
    assign pix = SP_BITS'(top_reg - 2'd2);

    // frame RAMs, one read address shared by all fields
    logic               fr_push;
    logic               fr_size_we;
    logic [SP_BITS-1:0] fr_size_waddr;
    logic [31:0]        fr_size_wdata;
    logic [SP_BITS-1:0] fr_raddr;
    logic [31:0]        fr_func_rdata;
    logic [31:0]        fr_stamp_rdata;
    logic [31:0]        fr_size_rdata;
    logic [47:0]        fr_cost_rdata;

    always_comb
    begin
        fr_push       = cmd.do_call && (top_reg != '0);
        fr_size_we    = fr_push | cmd.srch_dec;
        fr_size_waddr = cmd.srch_dec ? srch_reg : tix;
        fr_size_wdata = cmd.srch_dec ? (fr_size_rdata - 32'd1) : tf_size_reg;
        // fetch the next older frame in the cycle before its compare
        fr_raddr      = cmd.srch_step ? (srch_reg - 1'b1) : pix;
    end

    rmsp_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_func_ram (
        .clk   (clk),
        .we    (fr_push),
        .waddr (tix),
        .wdata (tf_func_reg),
        .raddr (fr_raddr),
        .rdata (fr_func_rdata)
    );

    rmsp_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stamp_fr_ram (
        .clk   (clk),
        .we    (fr_push),
        .waddr (tix),
        .wdata (tf_stamp_reg),
        .raddr (fr_raddr),
        .rdata (fr_stamp_rdata)
    );

    rmsp_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_size_ram (
        .clk   (clk),
        .we    (fr_size_we),
        .waddr (fr_size_waddr),
        .wdata (fr_size_wdata),
        .raddr (fr_raddr),
        .rdata (fr_size_rdata)
    );

    rmsp_ram #(.WIDTH(48), .DEPTH(STACK_DEPTH)) u_cost_ram (
        .clk   (clk),
        .we    (fr_push),
        .waddr (tix),
        .wdata (tf_cost_reg),
        .raddr (fr_raddr),
        .rdata (fr_cost_rdata)
    );

    // access stamp memory
    logic                 m_we;
    logic [ADDR_BITS-1:0] m_waddr;
    logic [31:0]          m_wdata;
    logic [31:0]          m_rdata;

    rmsp_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_stamp_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (cur_reg),
        .rdata (m_rdata)
    );

    always_comb
    begin
        m_we    = cmd.clr_step | cmd.byte_rd;
        m_waddr = cmd.clr_step ? clr_reg[ADDR_BITS-1:0] : cur_reg;
        m_wdata = cmd.clr_step ? 32'd0 : counter_reg;
    end

    always_comb
    begin
        sts.op        = req_reg.op;
        sts.empty     = (top_reg == '0);
        sts.full      = (top_reg == TOP_BITS'(STACK_DEPTH));
        sts.len_zero  = (req_reg.length == 16'd0);
        sts.last_byte = (left_reg == 16'd1);
        sts.clr_done  = clr_reg[ADDR_BITS];
        sts.need_srch = (m_rdata < tf_stamp_reg) && (m_rdata != 32'd0) && (tix != '0);
        sts.srch_hit  = (fr_stamp_rdata <= old_reg);
        sts.srch_end  = (srch_reg == '0);
        sts.out_busy  = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            top_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.do_call)
            begin
                counter_reg <= counter_reg + 32'd1;
                top_reg     <= top_reg + 1'b1;
            end
            if (cmd.ret_wr && tix != '0)
            begin
                top_reg <= top_reg - 1'b1;
            end
            if (cmd.ret_wr)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (cmd.out_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    logic [47:0] cost_sum;
    assign cost_sum = tf_cost_reg + 48'(req_reg.cost_in);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req;
            cur_reg  <= req.addr[ADDR_BITS-1:0];
            left_reg <= req.length;
        end
        if (cmd.advance)
        begin
            cur_reg  <= cur_reg + 1'b1;
            left_reg <= left_reg - 16'd1;
        end
        if (cmd.do_call)
        begin
            tf_func_reg  <= req_reg.func_id;
            tf_stamp_reg <= counter_reg + 32'd1;
            tf_size_reg  <= '0;
            tf_cost_reg  <= '0;
        end
        if (cmd.do_add)
        begin
            tf_size_reg <= tf_size_reg + 32'(req_reg.length);
        end
        if (cmd.ret_rd)
        begin
            tf_cost_reg <= cost_sum;
        end
        if (cmd.ret_wr)
        begin
            rsp_reg.out_func_id <= tf_func_reg;
            rsp_reg.call_stamp  <= tf_stamp_reg;
            rsp_reg.read_size   <= tf_size_reg;
            rsp_reg.total_cost  <= tf_cost_reg;
            rsp_reg.is_root     <= (tix == '0);
            // pop: the caller comes back from the RAMs with the totals merged
            if (tix != '0)
            begin
                tf_func_reg  <= fr_func_rdata;
                tf_stamp_reg <= fr_stamp_rdata;
                tf_size_reg  <= fr_size_rdata + tf_size_reg;
                tf_cost_reg  <= fr_cost_rdata + tf_cost_reg;
            end
        end
        if (cmd.byte_chk && m_rdata < tf_stamp_reg)
        begin
            tf_size_reg <= tf_size_reg + 32'd1;
        end
        if (cmd.byte_chk)
        begin
            old_reg  <= m_rdata;
            srch_reg <= pix;
        end
        if (cmd.srch_step)
        begin
            srch_reg <= srch_reg - 1'b1;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;
endmodule
`default_nettype wire

@@ src/rmsp_ctrl.sv @@
`default_nettype none
module rmsp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          out_stall,
    input  wire logic          enable,
    input  wire rmsp_pkg::sts_t sts,
    output rmsp_pkg::cmd_t     cmd
);
    import rmsp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_RET, S_RD_ISSUE, S_RD_CHECK,
        S_SEARCH, S_OUT_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd.out_take = sts.out_busy && !out_stall;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && enable)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (sts.op)
                    OP_CALL:
                    begin
                        cmd.do_call = !sts.full;
                    end
                    OP_RETURN:
                    begin
                        if (!sts.empty)
                        begin
                            if (sts.out_busy && out_stall)
                            begin
                                state_next = S_DISPATCH;
                            end
                            else
                            begin
                                cmd.ret_rd = 1'b1;
                                state_next = S_RET;
                            end
                        end
                    end
                    OP_READ, OP_WRITE:
                    begin
                        if (!sts.len_zero && !(sts.op == OP_READ && sts.empty))
                        begin
                            state_next = S_RD_ISSUE;
                        end
                    end
                    OP_ADD:
                    begin
                        cmd.do_add = !sts.empty;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RET:
            begin
                cmd.ret_wr   = 1'b1;
                cmd.out_take = 1'b0;
                state_next   = S_IDLE;
            end
            S_RD_ISSUE:
            begin
                // read old stamp and write the new one in the same cycle
                cmd.byte_rd = 1'b1;
                if (sts.op == OP_READ)
                begin
                    state_next = S_RD_CHECK;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    if (sts.last_byte)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RD_CHECK:
            begin
                cmd.byte_chk = 1'b1;
                if (sts.need_srch)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = sts.last_byte ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_SEARCH:
            begin
                // walk older frames down to the nearest one that saw the byte
                if (sts.srch_hit || sts.srch_end)
                begin
                    cmd.srch_dec = sts.srch_hit;
                    cmd.advance  = 1'b1;
                    state_next   = sts.last_byte ? S_IDLE : S_RD_ISSUE;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

@@ src/read_memory_size_profiler_top.sv @@
// Channel | Direction | Handshake        | Payload
// in      | input     | valid / stall    | req (op, func_id, addr, length, cost_in)
// out     | output    | valid / stall    | rsp (out_func_id, call_stamp, read_size,
//         |           |                  |      total_cost, is_root)
// cfg     | input     | cfg_we           | cfg_data (enable)
//
// A write range stamps its bytes in turn; a read range takes an issue and a
// check step per byte, as the stamp memory read is registered, plus a search
// step for each older frame visited. After reset a clearing pass over all
// 65536 words zeroes the stamp memory while no request is taken.
// A return waits while an earlier result is still stalled on the output.
`default_nettype none
module read_memory_size_profiler_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire rmsp_pkg::req_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output rmsp_pkg::rsp_t       out_data,
    input  wire logic            cfg_we,
    input  wire logic            cfg_data
);
    import rmsp_pkg::*;

    logic enable_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            enable_reg <= cfg_data;
        end
    end

    rmsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .enable    (enable_reg),
        .sts       (sts),
        .cmd       (cmd)
    );

    rmsp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (out_data),
        .rsp_valid (out_valid)
    );

    a_ret_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ret_wr |-> !(out_valid && out_stall))
        else $error("result overwritten while stalled");
    a_call_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_call |-> !sts.full)
        else $error("push on full stack");
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> in_stall)
        else $error("request taken during clear");
    a_ret_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ret_rd |-> !sts.empty)
        else $error("return on empty stack");
endmodule
`default_nettype wire

@@ tb/sv/tb_read_memory_size_profiler_top.sv @@
`timescale 1ns / 1ps
module tb_read_memory_size_profiler_top;
    import rmsp_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_ITEMS  = 220;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;
    logic cfg_we;
    logic cfg_data;

    read_memory_size_profiler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // shadow of the profiler state
    logic        prof_enable;
    logic [31:0] call_count;
    int          stack_level;
    logic [31:0] fr_func  [STACK_DEPTH];
    logic [31:0] fr_stamp [STACK_DEPTH];
    logic [31:0] fr_size  [STACK_DEPTH];
    logic [47:0] fr_cost  [STACK_DEPTH];
    logic [31:0] byte_stamp [MEM_WORDS];

    rsp_t frame_records[$];
    req_t pending_reqs[$];

    int idle_pct;
    int stall_pct;
    int errors;
    int cycles;
    int gen_level;
    int phase_max_len;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic stamp_read_byte(input logic [15:0] a);
        int top;
        logic [31:0] old;
        top = stack_level - 1;
        old = byte_stamp[a];
        byte_stamp[a] = call_count;
        if (old >= fr_stamp[top])
            return;
        fr_size[top] = fr_size[top] + 1;
        if (old == 0)
            return;
        for (int j = top; j > 0; j--)
        begin
            if (fr_stamp[j - 1] <= old)
            begin
                fr_size[j - 1] = fr_size[j - 1] - 1;
                break;
            end
        end
    endtask

    task automatic profile_request(input req_t r);
        int top;
        rsp_t rec;
        if (!prof_enable)
            return;
        case (r.op)
            OP_CALL:
                if (stack_level < STACK_DEPTH)
                begin
                    call_count = call_count + 1;
                    fr_func[stack_level]  = r.func_id;
                    fr_stamp[stack_level] = call_count;
                    fr_size[stack_level]  = '0;
                    fr_cost[stack_level]  = '0;
                    stack_level++;
                end
            OP_RETURN:
                if (stack_level > 0)
                begin
                    top = stack_level - 1;
                    fr_cost[top] = fr_cost[top] + 48'(r.cost_in);
                    rec.out_func_id = fr_func[top];
                    rec.call_stamp  = fr_stamp[top];
                    rec.read_size   = fr_size[top];
                    rec.total_cost  = fr_cost[top];
                    rec.is_root     = (top == 0);
                    frame_records.push_back(rec);
                    if (top != 0)
                    begin
                        fr_size[top - 1] = fr_size[top - 1] + fr_size[top];
                        fr_cost[top - 1] = fr_cost[top - 1] + fr_cost[top];
                        stack_level = top;
                    end
                end
            OP_READ:
                if (stack_level > 0)
                    for (int k = 0; k < int'(r.length); k++)
                        stamp_read_byte(r.addr + k[15:0]);
            OP_WRITE:
                for (int k = 0; k < int'(r.length); k++)
                    byte_stamp[r.addr + k[15:0]] = call_count;
            OP_ADD:
                if (stack_level > 0)
                    fr_size[stack_level - 1] = fr_size[stack_level - 1] + 32'(r.length);
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                profile_request(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_records.size() == 0)
                    report("unexpected result", 64'(out_data.out_func_id), 64'd0);
                else
                begin
                    rsp_t want;
                    want = frame_records.pop_front();
                    if (out_data.out_func_id !== want.out_func_id)
                        report("out_func_id", 64'(out_data.out_func_id),
                               64'(want.out_func_id));
                    if (out_data.call_stamp !== want.call_stamp)
                        report("call_stamp", 64'(out_data.call_stamp), 64'(want.call_stamp));
                    if (out_data.read_size !== want.read_size)
                        report("read_size", 64'(out_data.read_size), 64'(want.read_size));
                    if (out_data.total_cost !== want.total_cost)
                        report("total_cost", 64'(out_data.total_cost), 64'(want.total_cost));
                    if (out_data.is_root !== want.is_root)
                        report("is_root", 64'(out_data.is_root), 64'(want.is_root));
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic req_t make_req(input logic [2:0] op, input logic [31:0] fid,
                                      input logic [15:0] addr, input logic [15:0] len,
                                      input logic [31:0] cost);
        req_t r;
        r.op      = op;
        r.func_id = fid;
        r.addr    = addr;
        r.length  = len;
        r.cost_in = cost;
        return r;
    endfunction

    task automatic push_req(input req_t r);
        if ((r.op == OP_READ || r.op == OP_WRITE) && int'(r.length) > phase_max_len)
            phase_max_len = int'(r.length);
        pending_reqs.push_back(r);
    endtask

    // mostly well-formed call/access/return traffic over a small address window
    task automatic push_random(input int call_w);
        int pick;
        logic [2:0] op;
        logic [15:0] addr;
        logic [15:0] len;
        pick = $urandom_range(99);
        if (gen_level == 0 || pick < call_w)
            op = OP_CALL;
        else if (pick < call_w + 20)
            op = OP_RETURN;
        else if (pick < call_w + 48)
            op = OP_READ;
        else if (pick < call_w + 62)
            op = OP_WRITE;
        else if (pick < 97)
            op = OP_ADD;
        else
            op = 3'($urandom_range(7, 5));
        if ($urandom_range(9) == 0)
            addr = 16'($urandom);
        else
            addr = 16'h7FC0 + 16'($urandom_range(127));
        if (op == OP_ADD && $urandom_range(3) == 0)
            len = 16'($urandom);
        else
            len = 16'($urandom_range(16));
        if (op == OP_CALL && gen_level < STACK_DEPTH)
            gen_level++;
        if (op == OP_RETURN && gen_level > 1)
            gen_level--;
        push_req(make_req(op, $urandom, addr, len, $urandom));
    endtask

    task automatic write_enable(input logic v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        prof_enable = v;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid)
            @(negedge clk);
        while (frame_records.size() > 0)
            @(negedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (2000 + 3 * phase_max_len) @(negedge clk);
        phase_max_len = 0;
    endtask

    task automatic random_phase(input int n, input int idle, input int stall, input int call_w);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n / 2; i++)
            push_random(call_w);
        // hold new requests until every pending return has come out
        drain();
        for (int i = n / 2; i < n; i++)
            push_random(call_w);
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        cycles = 0;
        gen_level = 0;
        phase_max_len = 0;
        prof_enable = 1'b0;
        call_count = '0;
        stack_level = 0;
        for (int i = 0; i < MEM_WORDS; i++)
            byte_stamp[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // disabled: everything is dropped
        write_enable(1'b0);
        for (int i = 0; i < 20; i++)
            push_req(make_req(3'($urandom), $urandom, 16'($urandom), 16'($urandom_range(8)),
                              $urandom));
        settle();

        write_enable(1'b1);
        idle_pct = 30;
        stall_pct = 30;
        push_req(make_req(OP_RETURN, 32'h1, 16'h0, 16'h0, 32'h5));
        push_req(make_req(OP_READ, 32'h0, 16'h0010, 16'h4, 32'h0));
        push_req(make_req(OP_ADD, 32'h0, 16'h0, 16'h7, 32'h0));
        push_req(make_req(OP_WRITE, 32'h0, 16'hFFF8, 16'h10, 32'h0));
        push_req(make_req(OP_CALL, 32'h0, 16'h0, 16'h0, 32'h0));
        push_req(make_req(OP_READ, 32'h0, 16'hFFFC, 16'h8, 32'h0));
        push_req(make_req(OP_READ, 32'h0, 16'h0100, 16'h0, 32'h0));
        push_req(make_req(OP_ADD, 32'h0, 16'h0, 16'hFFFF, 32'h0));
        push_req(make_req(OP_ADD, 32'h0, 16'h0, 16'h0, 32'h0));
        push_req(make_req(OP_CALL, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
        push_req(make_req(OP_READ, 32'h0, 16'hFFFE, 16'h6, 32'h0));
        push_req(make_req(OP_CALL, 32'h1234, 16'h0, 16'h0, 32'h0));
        push_req(make_req(OP_READ, 32'h0, 16'hFFF9, 16'h10, 32'h0));
        push_req(make_req(3'd5, 32'h0, 16'h0, 16'h1, 32'h0));
        push_req(make_req(3'd6, 32'h0, 16'h0, 16'h1, 32'h0));
        push_req(make_req(3'd7, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
        push_req(make_req(OP_RETURN, 32'h0, 16'h0, 16'h0, 32'hFFFFFFFF));
        push_req(make_req(OP_RETURN, 32'h0, 16'h0, 16'h0, 32'hFFFFFFFF));
        push_req(make_req(OP_RETURN, 32'h0, 16'h0, 16'h0, 32'h0));
        push_req(make_req(OP_RETURN, 32'h0, 16'h0, 16'h0, 32'h1));
        // full-width read with only the root frame, so no stack search
        push_req(make_req(OP_READ, 32'h0, 16'h0, 16'hFFFF, 32'h0));
        push_req(make_req(OP_RETURN, 32'h0, 16'h0, 16'h0, 32'h0));
        settle();
        gen_level = 1;

        random_phase(RAND_ITEMS, 0, 0, 22);
        random_phase(RAND_ITEMS, 80, 0, 22);
        write_enable(1'b0);
        for (int i = 0; i < 10; i++)
            push_req(make_req(OP_CALL, $urandom, 16'h0, 16'h0, 32'h0));
        settle();
        write_enable(1'b1);
        random_phase(RAND_ITEMS, 0, 80, 22);
        // call-heavy traffic runs the stack into overflow
        random_phase(120, 0, 0, 70);
        random_phase(RAND_ITEMS, 19, 19, 22);

        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
src/rmsp_pkg.sv
src/rmsp_ram.sv
src/rmsp_datapath.sv
src/rmsp_ctrl.sv
src/read_memory_size_profiler_top.sv
tb/sv/tb_read_memory_size_profiler_top.sv
